### hw/rtl/bmtb_pkg.sv
// package for the boyer-moore table builder
// constants, item codes and sequencer state type; no dependencies
`default_nettype none

package bmtb_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int ALPHABET    = 256;
    localparam int TBL_DEPTH   = MAX_PATTERN + 1;
    localparam int CNT_W       = 7;
    localparam int PAT_AW      = $clog2(MAX_PATTERN);
    localparam int TBL_AW      = $clog2(TBL_DEPTH);
    localparam int BC_AW       = $clog2(ALPHABET);
    localparam int SHIFT_W     = 7;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_RD_BC  = 2'd1,
        MODE_RD_GS  = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_BUILT = 2'd1,
        ST_RANGE     = 2'd2,
        ST_TOO_LONG  = 2'd3
    } status_t;

    typedef enum logic [17:0] {
        S_IDLE  = 18'h00001,
        S_RD    = 18'h00002,
        S_BCLR  = 18'h00004,
        S_BCR   = 18'h00008,
        S_BCW   = 18'h00010,
        S_GINIT = 18'h00020,
        S_BK1   = 18'h00040,
        S_BK2   = 18'h00080,
        S_BK3   = 18'h00100,
        S_BK4   = 18'h00200,
        S_BK5   = 18'h00400,
        S_BKDEC = 18'h00800,
        S_T1    = 18'h01000,
        S_T2    = 18'h02000,
        S_F1    = 18'h04000,
        S_F2    = 18'h08000,
        S_F3    = 18'h10000,
        S_F4    = 18'h20000
    } state_t;

endpackage

`default_nettype wire

### hw/rtl/bmtb_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module bmtb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/boyer_moore_table_builder_unit.sv
// top level of the boyer-moore table builder: sequencer, shared lower/compare unit
// uses bmtb_pkg and four bmtb_ram instances
//
// input channel s_*: one item per handshake. s_tuser carries the mode
// (load byte, read bad-character entry, read good-suffix entry), s_tlast marks
// the final pattern byte. every item except mode 3 answers one item on m_*.
// a load, or a read refused as not built or out of range, answers in the
// cycle after acceptance; other reads pass S_RD and the registered table ram.
// the load marked last starts the build: a sweep sets every bad-character
// entry to the pattern length, a pass over the pattern fills the table, a
// pass seeds the good-suffix table, the backup chain walk visits each
// position and follows the chain on each mismatch (at most L mismatches),
// and the prefix and border passes lower the remaining entries.
// s_tready is low during the build and during a read; the block handles one
// item at a time.
// the result register frees s_tready again as soon as m_tready takes the
// pending item; a stalled receiver just holds s_tready low.
// reset clears the count, overflow and tables-built flags; table contents
// are undefined until the first build writes them.
`default_nettype none

module boyer_moore_table_builder_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [7:0] pattern_byte, [15:8] lookup_index
    input  wire logic [bmtb_pkg::IN_TDATA_W-1:0]    s_tdata,
    // [1:0] mode
    input  wire logic [1:0]                         s_tuser,
    input  wire logic                               s_tlast,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [6:0] shift_value, [13:7] stored_length, [15:14] zero
    output logic      [bmtb_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // [1:0] status
    output logic      [1:0]                         m_tuser
);

    import bmtb_pkg::*;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic ovf_reg, ovf_next;
    logic built_reg, built_next;
    logic [CNT_W-1:0] u_reg, u_next;
    logic [CNT_W-1:0] ua_reg, ua_next;
    logic [CNT_W-1:0] ub_reg, ub_next;
    logic [BC_AW-1:0] sweep_reg, sweep_next;
    logic [7:0] pu_reg, pu_next;
    logic rd_gs_reg, rd_gs_next;

    // result register
    logic m_valid_reg, m_valid_next;
    logic [SHIFT_W-1:0] m_shift_reg, m_shift_next;
    logic [CNT_W-1:0] m_len_reg, m_len_next;
    status_t m_status_reg, m_status_next;
    logic m_load;

    // ram ports
    logic pat_we;
    logic [PAT_AW-1:0] pat_waddr, pat_raddr;
    logic [7:0] pat_wdata, pat_rdata;
    logic bc_we;
    logic [BC_AW-1:0] bc_waddr, bc_raddr;
    logic [SHIFT_W-1:0] bc_wdata, bc_rdata;
    logic gs_we;
    logic [TBL_AW-1:0] gs_waddr, gs_raddr;
    logic [SHIFT_W-1:0] gs_wdata, gs_rdata;
    logic bk_we;
    logic [TBL_AW-1:0] bk_waddr, bk_raddr;
    logic [SHIFT_W-1:0] bk_wdata, bk_rdata;

    // input fields
    mode_t in_mode;
    logic [7:0] in_byte;
    logic [7:0] in_idx;
    logic in_accept;
    logic [CNT_W-1:0] cnt_eff;
    logic ovf_eff;

    // shared candidate unit: a + b - c, then compare with the table entry
    logic [CNT_W-1:0] op_b, op_c;
    logic [CNT_W:0] cand;
    logic lower_hit;

    assign in_mode   = mode_t'(s_tuser);
    assign in_byte   = s_tdata[7:0];
    assign in_idx    = s_tdata[15:8];
    assign s_tready  = (state_reg == S_IDLE) && (!m_valid_reg || m_tready);
    assign in_accept = s_tvalid && s_tready;
    assign cnt_eff   = built_reg ? '0 : cnt_reg;
    assign ovf_eff   = built_reg ? 1'b0 : ovf_reg;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_len_reg, m_shift_reg};
    assign m_tuser  = m_status_reg;

    always_comb
    begin
        case (state_reg)
            S_BK5:
            begin
                op_b = '0;
                op_c = u_reg;
            end
            S_T2:
            begin
                op_b = ua_reg;
                op_c = u_reg;
            end
            S_F4:
            begin
                op_b = ub_reg;
                op_c = ua_reg;
            end
            default:
            begin
                op_b = '0;
                op_c = '0;
            end
        endcase
        cand      = {1'b0, cnt_reg} + {1'b0, op_b} - {1'b0, op_c};
        lower_hit = {1'b0, gs_rdata} > cand;
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ovf_next      = ovf_reg;
        built_next    = built_reg;
        u_next        = u_reg;
        ua_next       = ua_reg;
        ub_next       = ub_reg;
        sweep_next    = sweep_reg;
        pu_next       = pu_reg;
        rd_gs_next    = rd_gs_reg;
        m_load        = 1'b0;
        m_shift_next  = m_shift_reg;
        m_len_next    = m_len_reg;
        m_status_next = m_status_reg;

        pat_we    = 1'b0;
        pat_waddr = cnt_eff[PAT_AW-1:0];
        pat_wdata = in_byte;
        pat_raddr = u_reg[PAT_AW-1:0];
        bc_we     = 1'b0;
        bc_waddr  = sweep_reg;
        bc_wdata  = cnt_reg;
        bc_raddr  = in_idx;
        gs_we     = 1'b0;
        gs_waddr  = u_reg[TBL_AW-1:0];
        gs_wdata  = cand[SHIFT_W-1:0];
        gs_raddr  = in_idx[TBL_AW-1:0];
        bk_we     = 1'b0;
        bk_waddr  = u_reg[TBL_AW-1:0];
        bk_wdata  = ua_reg;
        bk_raddr  = ua_reg[TBL_AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    case (in_mode)
                        MODE_LOAD:
                        begin
                            built_next = 1'b0;
                            if (cnt_eff < CNT_W'(MAX_PATTERN))
                            begin
                                pat_we   = 1'b1;
                                cnt_next = cnt_eff + 1'b1;
                                ovf_next = ovf_eff;
                            end
                            else
                            begin
                                cnt_next = cnt_eff;
                                ovf_next = 1'b1;
                            end
                            m_load        = 1'b1;
                            m_shift_next  = '0;
                            m_len_next    = (cnt_eff < CNT_W'(MAX_PATTERN)) ?
                                            cnt_eff + 1'b1 : cnt_eff;
                            m_status_next = (ovf_eff ||
                                             !(cnt_eff < CNT_W'(MAX_PATTERN))) ?
                                            ST_TOO_LONG : ST_OK;
                            if (s_tlast)
                            begin
                                sweep_next = '0;
                                state_next = S_BCLR;
                            end
                        end
                        MODE_RD_BC, MODE_RD_GS:
                        begin
                            m_len_next = cnt_reg;
                            if (!built_reg)
                            begin
                                m_load        = 1'b1;
                                m_shift_next  = '0;
                                m_status_next = ST_NOT_BUILT;
                            end
                            else if (in_mode == MODE_RD_GS &&
                                     (in_idx == 8'd0 || in_idx > {1'b0, cnt_reg}))
                            begin
                                m_load        = 1'b1;
                                m_shift_next  = '0;
                                m_status_next = ST_RANGE;
                            end
                            else
                            begin
                                rd_gs_next = (in_mode == MODE_RD_GS);
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RD:
            begin
                m_load        = 1'b1;
                m_shift_next  = rd_gs_reg ? gs_rdata : bc_rdata;
                m_len_next    = cnt_reg;
                m_status_next = ST_OK;
                state_next    = S_IDLE;
            end
            // every bad-character entry starts at the pattern length
            S_BCLR:
            begin
                bc_we = 1'b1;
                if (sweep_reg == '1)
                begin
                    u_next     = '0;
                    state_next = S_BCR;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            S_BCR:
            begin
                if (u_reg < cnt_reg)
                begin
                    state_next = S_BCW;
                end
                else
                begin
                    u_next     = CNT_W'(1);
                    state_next = S_GINIT;
                end
            end
            // later positions overwrite earlier ones
            S_BCW:
            begin
                bc_we      = 1'b1;
                bc_waddr   = pat_rdata;
                bc_wdata   = cnt_reg - u_reg - 1'b1;
                u_next     = u_reg + 1'b1;
                state_next = S_BCR;
            end
            S_GINIT:
            begin
                if (u_reg <= cnt_reg)
                begin
                    gs_we      = 1'b1;
                    gs_wdata   = SHIFT_W'({cnt_reg, 1'b0} - {1'b0, u_reg});
                    u_next     = u_reg + 1'b1;
                end
                else
                begin
                    u_next     = cnt_reg;
                    ua_next    = cnt_reg + 1'b1;
                    state_next = S_BK1;
                end
            end
            // backup chain: outer step
            S_BK1:
            begin
                if (u_reg == '0)
                begin
                    u_next     = CNT_W'(1);
                    state_next = S_T1;
                end
                else
                begin
                    bk_we      = 1'b1;
                    pat_raddr  = PAT_AW'(u_reg - 1'b1);
                    state_next = S_BK2;
                end
            end
            S_BK2:
            begin
                pu_next    = pat_rdata;
                state_next = S_BK3;
            end
            S_BK3:
            begin
                if (ua_reg >= CNT_W'(1) && ua_reg <= cnt_reg)
                begin
                    pat_raddr  = PAT_AW'(ua_reg - 1'b1);
                    state_next = S_BK4;
                end
                else
                begin
                    state_next = S_BKDEC;
                end
            end
            S_BK4:
            begin
                if (pat_rdata != pu_reg)
                begin
                    gs_raddr   = ua_reg[TBL_AW-1:0];
                    bk_raddr   = ua_reg[TBL_AW-1:0];
                    state_next = S_BK5;
                end
                else
                begin
                    state_next = S_BKDEC;
                end
            end
            // mismatch: lower the entry at ua and follow the chain
            S_BK5:
            begin
                gs_waddr   = ua_reg[TBL_AW-1:0];
                gs_we      = lower_hit;
                ua_next    = bk_rdata;
                state_next = S_BK3;
            end
            S_BKDEC:
            begin
                u_next     = u_reg - 1'b1;
                ua_next    = ua_reg - 1'b1;
                state_next = S_BK1;
            end
            // prefix part below the first border
            S_T1:
            begin
                if (u_reg <= ua_reg && u_reg <= cnt_reg)
                begin
                    gs_raddr   = u_reg[TBL_AW-1:0];
                    state_next = S_T2;
                end
                else
                begin
                    ub_next    = ua_reg;
                    state_next = S_F1;
                end
            end
            S_T2:
            begin
                gs_waddr   = u_reg[TBL_AW-1:0];
                gs_we      = lower_hit;
                u_next     = u_reg + 1'b1;
                state_next = S_T1;
            end
            // remaining borders along the backup chain
            S_F1:
            begin
                if (ua_reg <= cnt_reg)
                begin
                    bk_raddr   = ub_reg[TBL_AW-1:0];
                    state_next = S_F2;
                end
                else
                begin
                    built_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_F2:
            begin
                if (bk_rdata <= ub_reg)
                begin
                    built_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ub_next    = bk_rdata;
                    state_next = S_F3;
                end
            end
            S_F3:
            begin
                if (ua_reg <= ub_reg)
                begin
                    gs_raddr   = ua_reg[TBL_AW-1:0];
                    state_next = S_F4;
                end
                else
                begin
                    state_next = S_F1;
                end
            end
            S_F4:
            begin
                gs_waddr   = ua_reg[TBL_AW-1:0];
                gs_we      = lower_hit && ua_reg >= CNT_W'(1) && ua_reg <= cnt_reg;
                ua_next    = ua_reg + 1'b1;
                state_next = S_F3;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (m_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            built_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            built_reg   <= built_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg        <= u_next;
        ua_reg       <= ua_next;
        ub_reg       <= ub_next;
        sweep_reg    <= sweep_next;
        pu_reg       <= pu_next;
        rd_gs_reg    <= rd_gs_next;
        m_shift_reg  <= m_shift_next;
        m_len_reg    <= m_len_next;
        m_status_reg <= m_status_next;
    end

    bmtb_ram #(.WIDTH(8), .DEPTH(MAX_PATTERN)) u_pat_ram (
        .clk   (clk),
        .we    (pat_we),
        .waddr (pat_waddr),
        .wdata (pat_wdata),
        .raddr (pat_raddr),
        .rdata (pat_rdata)
    );

    bmtb_ram #(.WIDTH(SHIFT_W), .DEPTH(ALPHABET)) u_bc_ram (
        .clk   (clk),
        .we    (bc_we),
        .waddr (bc_waddr),
        .wdata (bc_wdata),
        .raddr (bc_raddr),
        .rdata (bc_rdata)
    );

    bmtb_ram #(.WIDTH(SHIFT_W), .DEPTH(TBL_DEPTH)) u_gs_ram (
        .clk   (clk),
        .we    (gs_we),
        .waddr (gs_waddr),
        .wdata (gs_wdata),
        .raddr (gs_raddr),
        .rdata (gs_rdata)
    );

    bmtb_ram #(.WIDTH(SHIFT_W), .DEPTH(TBL_DEPTH)) u_bk_ram (
        .clk   (clk),
        .we    (bk_we),
        .waddr (bk_waddr),
        .wdata (bk_wdata),
        .raddr (bk_raddr),
        .rdata (bk_rdata)
    );

    // a table read never finds the result register still occupied
    a_rd_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RD |-> !m_valid_reg)
        else $error("table read while result register busy");

    // pattern count never exceeds the store depth
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_PATTERN))
        else $error("pattern count beyond store depth");

    // a last load starts the clearing sweep
    a_build_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && in_mode == MODE_LOAD && s_tlast |=> state_reg == S_BCLR)
        else $error("build did not start after last byte");

    // tables only become valid at the end of the chain walk
    a_built_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(built_reg) |-> ($past(state_reg) == S_F1 || $past(state_reg) == S_F2))
        else $error("tables flagged built outside the final walk");

endmodule

`default_nettype wire

### tb/tb_boyer_moore_table_builder_unit.sv
// testbench for the boyer-moore table builder: stream driver, receiver and scoreboard
// depends on bmtb_pkg and boyer_moore_table_builder_unit
`timescale 1ns / 100ps

module tb_boyer_moore_table_builder_unit;
    import bmtb_pkg::*;

    typedef struct packed {
        logic [6:0] shift_value;
        logic [6:0] stored_length;
        status_t    status;
    } bm_answer_t;

    // own copy of the block state and the expected answers
    class bm_table_scoreboard;
        logic [7:0]  pat[MAX_PATTERN];
        int          count;
        bit          overflow;
        bit          ready;
        int          bad_char[ALPHABET];
        int          good_suf[MAX_PATTERN + 2];
        int          backup[MAX_PATTERN + 2];
        bm_answer_t  pending[$];
        int          mismatches;

        function void clear_state();
            count = 0;
            overflow = 0;
            ready = 0;
            mismatches = 0;
            pending.delete();
        endfunction

        function void lower_gs(int i, int v);
            if (i < MAX_PATTERN + 2 && good_suf[i] > v)
                good_suf[i] = v;
        endfunction

        function int rd_backup(int i);
            return (i < MAX_PATTERN + 2) ? backup[i] : 0;
        endfunction

        function void build_tables();
            int n;
            int u;
            int ua;
            int ub;
            int nb;
            n = count;
            for (u = 0; u < ALPHABET; u++)
                bad_char[u] = n;
            for (u = 0; u < n; u++)
                bad_char[pat[u]] = n - u - 1;
            for (u = 1; u <= n; u++)
                good_suf[u] = 2 * n - u;
            u = n;
            ua = n + 1;
            while (u > 0)
            begin
                backup[u] = ua;
                while (ua >= 1 && ua <= n && pat[u - 1] != pat[ua - 1])
                begin
                    lower_gs(ua, n - u);
                    ua = rd_backup(ua);
                end
                u--;
                ua--;
            end
            for (u = 1; u <= ua && u <= n; u++)
                lower_gs(u, n + ua - u);
            ub = ua;
            while (ua <= n)
            begin
                nb = rd_backup(ub);
                if (nb <= ub)
                    break;
                ub = nb;
                while (ua <= ub)
                begin
                    lower_gs(ua, ub - ua + n);
                    ua++;
                end
            end
            ready = 1;
        endfunction

        function int sat(int v);
            return (v > 127) ? 127 : v;
        endfunction

        // note an accepted input item and queue what it should answer
        function void note_input(mode_t mode, logic [7:0] pbyte, logic lst, logic [7:0] idx);
            bm_answer_t a;
            if (mode == MODE_UNUSED)
                return;
            a.shift_value = '0;
            a.status = ST_OK;
            if (mode == MODE_LOAD)
            begin
                if (ready)
                begin
                    count = 0;
                    overflow = 0;
                    ready = 0;
                end
                if (count < MAX_PATTERN)
                begin
                    pat[count] = pbyte;
                    count++;
                end
                else
                    overflow = 1;
                a.status = overflow ? ST_TOO_LONG : ST_OK;
                if (lst)
                    build_tables();
            end
            else if (!ready)
                a.status = ST_NOT_BUILT;
            else if (mode == MODE_RD_BC)
                a.shift_value = 7'(sat(bad_char[idx]));
            else if (idx < 1 || idx > count)
                a.status = ST_RANGE;
            else
                a.shift_value = 7'(sat(good_suf[idx]));
            a.stored_length = 7'(count);
            pending.push_back(a);
        endfunction

        function void check_answer(bm_answer_t got);
            bm_answer_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item %h", got);
                return;
            end
            want = pending.pop_front();
            if (want.shift_value !== got.shift_value
                || want.stored_length !== got.stored_length
                || want.status !== got.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: shift exp %0d got %0d, length exp %0d got %0d,",
                              " status exp %0d got %0d"},
                             want.shift_value, got.shift_value, want.stored_length,
                             got.stored_length, want.status, got.status);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;

    bm_table_scoreboard board;
    int  send_idle_pct;       // sender idle chance in percent
    int  recv_idle_pct;       // receiver stall chance in percent
    int  hold_off_cycles;     // long receiver stall requested by the stimulus
    int  tick;                // cycles since simulation start, for the drain wait

    boyer_moore_table_builder_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] pattern_byte, [15:8] lookup_index
        .s_tuser  (s_tuser),   // [1:0] mode
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [6:0] shift_value, [13:7] stored_length
        .m_tuser  (m_tuser)    // [1:0] status
    );

    always #1 clk = ~clk;

    always @(posedge clk)
        tick <= tick + 1;

    // offer one item; it is noted in the scoreboard at the accepting edge
    task automatic send_item(mode_t mode, logic [7:0] pbyte, logic lst, logic [7:0] idx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {idx, pbyte};
        s_tlast  <= lst;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_input(mode, pbyte, lst, idx);
        @(negedge clk);
    endtask

    // n bytes from a small alphabet so suffixes repeat, or any byte if alpha >= 256
    task automatic send_pattern(int n, int alpha);
        for (int i = 0; i < n; i++)
            send_item(MODE_LOAD, (alpha >= 256) ? 8'($urandom) : 8'($urandom_range(alpha - 1)),
                      i == n - 1, 8'($urandom));
    endtask

    task automatic send_reads(int k, int n);
        for (int i = 0; i < k; i++)
        begin
            case ($urandom_range(9))
                0:       send_item(MODE_UNUSED, 8'($urandom), 1'($urandom), 8'($urandom));
                1, 2, 3: send_item(MODE_RD_BC, 8'($urandom), 1'($urandom), 8'($urandom));
                4:       send_item(MODE_RD_GS, 8'($urandom), 1'($urandom), 8'($urandom));
                default: send_item(MODE_RD_GS, 8'($urandom), 1'($urandom),
                                   8'($urandom_range(n + 1)));
            endcase
        end
    endtask

    // receiver: random stalls plus the long hold-off; results checked at the edge
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            board.check_answer({m_tdata[6:0], m_tdata[13:7], status_t'(m_tuser)});

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int n;
        int phase;
        int last_tick;
        clk = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = MODE_LOAD;
        s_tlast = 0;
        m_tready = 0;
        hold_off_cycles = 0;
        tick = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        board = new();
        board.clear_state();
        repeat (10) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: reads before build, extremes, single-byte pattern, overflow
        send_item(MODE_RD_BC, 8'h00, 1'b0, 8'hff);
        send_item(MODE_RD_GS, 8'hff, 1'b1, 8'h01);
        send_item(MODE_UNUSED, 8'hff, 1'b1, 8'hff);
        send_item(MODE_LOAD, 8'hff, 1'b1, 8'hff);
        send_item(MODE_RD_BC, 8'h00, 1'b0, 8'hff);
        send_item(MODE_RD_BC, 8'h00, 1'b0, 8'h00);
        send_item(MODE_RD_GS, 8'h00, 1'b0, 8'h00);
        send_item(MODE_RD_GS, 8'h00, 1'b0, 8'h01);
        send_item(MODE_RD_GS, 8'h00, 1'b0, 8'h02);
        send_item(MODE_RD_GS, 8'h00, 1'b0, 8'hff);
        // too long: 66 bytes, the last dropped one still builds
        for (int i = 0; i < 66; i++)
            send_item(MODE_LOAD, 8'(i % 3), i == 65, 8'h00);
        send_item(MODE_RD_GS, 8'h00, 1'b0, 8'd64);
        send_item(MODE_RD_GS, 8'h00, 1'b0, 8'd65);
        send_item(MODE_RD_BC, 8'h00, 1'b0, 8'h02);

        // long receiver stall while items keep coming
        hold_off_cycles = 400;
        send_pattern(5, 2);
        send_reads(10, 5);

        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 85 : 0;
            recv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 16 : 0;
            for (int p = 0; p < 14; p++)
            begin
                n = ($urandom_range(15) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
                send_pattern(n, (p % 4 == 3) ? 256 : $urandom_range(1, 3));
                send_reads(16, n);
            end
        end
        s_tvalid <= 1'b0;

        last_tick = tick;
        while (board.pending.size() != 0 && tick - last_tick < 20000)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
